### design/assert_macros.svh
// Assertion macros used by the checker file of the cluster chain manager.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/fccm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the FAT12 cluster chain manager.
// No dependencies; every module file imports it.
package fccm_pkg;

  localparam int ENTRIES = 4096;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int FAT_W   = 12;
  localparam int LIM_W   = 13;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [LIM_W-1:0] LIM_ENTRIES   = LIM_W'(ENTRIES);
  localparam logic [LIM_W-1:0] FIRST_CLUSTER = LIM_W'(2);
  localparam logic [LIM_W-1:0] LIMIT_RST     = LIM_W'(3072);
  localparam logic [FAT_W-1:0] MARK_RST      = 12'hFFF;
  localparam logic [FAT_W-1:0] FAT_RST0      = 12'hFF0;
  localparam logic [FAT_W-1:0] FAT_RST1      = 12'hFFF;
  localparam logic [FAT_W-1:0] END_THRESH    = 12'hFF8;
  localparam logic [FAT_W-1:0] MIN_LINK      = 12'd2;

  localparam logic [MODE_W-1:0] MODE_READ  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CORRUPT   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_COUNT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARK    = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [11:0]       entry_index;
    logic [11:0]       entry_value;
    logic [11:0]       cluster_count;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [12:0]       result_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_COUNT,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_EVAL,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LATCH,
    DP_FIN_ZERO,
    DP_FIN_COUNT,
    DP_RD_ISSUE,
    DP_RD_DONE,
    DP_WRITE,
    DP_SCAN_INIT,
    DP_CNT_STEP,
    DP_ALLOC_INIT,
    DP_ALLOC_STEP,
    DP_ALLOC_END,
    DP_FREE_INIT,
    DP_FREE_RD,
    DP_FREE_EVAL
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STAT_W-1:0] fin_status;
    logic              load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              clr_done;
    logic              bad_idx;
    logic              zero_cnt;
    logic              no_space;
    logic              free_bad_start;
    logic              scan_done;
    logic              alloc_done;
    logic              walk_over;
    logic              walk_end;
    logic              walk_bad;
  } dp_sts_t;

endpackage

### design/fccm_dp.sv
`timescale 1ns / 1ps
// Datapath: allocation table memory, config registers, scan and walk counters.
// Driven by fccm_ctrl through dp_cmd_t; depends on fccm_pkg.
module fccm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fccm_pkg::in_item_t               in_data,
  input  logic                             cfg_valid,
  input  logic [fccm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fccm_pkg::LIM_W-1:0]       cfg_data,
  input  fccm_pkg::dp_cmd_t                cmd,
  output fccm_pkg::dp_sts_t                sts,
  output fccm_pkg::out_item_t              out_data
);
  import fccm_pkg::*;

  logic [FAT_W-1:0] mem [ENTRIES];
  logic [FAT_W-1:0] rd_data_r;

  logic [LIM_W-1:0] cfg_limit_r;
  logic [FAT_W-1:0] cfg_mark_r;

  in_item_t         req_r,       req_nxt;
  logic [IDX_W-1:0] clr_r,       clr_nxt;
  logic [LIM_W-1:0] scan_r,      scan_nxt;
  logic             pend_vld_r,  pend_vld_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [LIM_W-1:0] cnt_r,       cnt_nxt;
  logic [11:0]      got_r,       got_nxt;
  logic [IDX_W-1:0] prev_r,      prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [IDX_W-1:0] cur_r,       cur_nxt;
  logic [STAT_W-1:0] stat_r,     stat_nxt;
  logic [LIM_W-1:0] value_r,     value_nxt;
  out_item_t        out_r,       out_nxt;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [FAT_W-1:0] mem_wdata;

  logic [LIM_W-1:0] lim;
  logic [IDX_W-1:0] req_idx;
  logic             scan_lt;
  logic             rd_zero;
  logic             got_full;

  assign lim      = (cfg_limit_r > LIM_ENTRIES) ? LIM_ENTRIES : cfg_limit_r;
  assign req_idx  = req_r.entry_index[IDX_W-1:0];
  assign scan_lt  = scan_r < lim;
  assign rd_zero  = rd_data_r == '0;
  assign got_full = got_r == req_r.cluster_count;

  always_comb begin
    sts.mode           = req_r.mode;
    sts.clr_done       = clr_r == IDX_W'(ENTRIES - 1);
    sts.bad_idx        = {1'b0, req_r.entry_index} >= LIM_ENTRIES;
    sts.zero_cnt       = req_r.cluster_count == '0;
    sts.no_space       = cnt_r < {1'b0, req_r.cluster_count};
    sts.free_bad_start = (req_r.entry_index < MIN_LINK) ||
                         ({1'b0, req_r.entry_index} >= lim);
    sts.scan_done      = !scan_lt && !pend_vld_r;
    sts.alloc_done     = got_full;
    sts.walk_over      = cnt_r >= lim;
    sts.walk_end       = rd_data_r >= END_THRESH;
    sts.walk_bad       = (rd_data_r < MIN_LINK) || ({1'b0, rd_data_r} >= lim);
  end

  always_comb begin
    req_nxt       = req_r;
    clr_nxt       = clr_r;
    scan_nxt      = scan_r;
    pend_vld_nxt  = 1'b0;
    pend_addr_nxt = pend_addr_r;
    cnt_nxt       = cnt_r;
    got_nxt       = got_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    cur_nxt       = cur_r;
    stat_nxt      = stat_r;
    value_nxt     = value_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    case (cmd.op)
      DP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == '0) begin
          mem_wdata = FAT_RST0;
        end else if (clr_r == IDX_W'(1)) begin
          mem_wdata = FAT_RST1;
        end
        clr_nxt = clr_r + 1'b1;
      end
      DP_LATCH: begin
        req_nxt = in_data;
      end
      DP_FIN_ZERO: begin
        stat_nxt  = cmd.fin_status;
        value_nxt = '0;
      end
      DP_FIN_COUNT: begin
        stat_nxt  = cmd.fin_status;
        value_nxt = cnt_r;
      end
      DP_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = req_idx;
      end
      DP_RD_DONE: begin
        stat_nxt  = STAT_OK;
        value_nxt = {1'b0, rd_data_r};
      end
      DP_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = req_idx;
        mem_wdata = req_r.entry_value;
        stat_nxt  = STAT_OK;
        value_nxt = '0;
      end
      DP_SCAN_INIT: begin
        scan_nxt = FIRST_CLUSTER;
        cnt_nxt  = '0;
      end
      DP_CNT_STEP: begin
        if (scan_lt) begin
          mem_re        = 1'b1;
          mem_raddr     = scan_r[IDX_W-1:0];
          pend_vld_nxt  = 1'b1;
          pend_addr_nxt = scan_r[IDX_W-1:0];
          scan_nxt      = scan_r + 1'b1;
        end
        if (pend_vld_r && rd_zero) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      DP_ALLOC_INIT: begin
        scan_nxt      = FIRST_CLUSTER;
        got_nxt       = '0;
        have_prev_nxt = 1'b0;
        stat_nxt      = STAT_OK;
        value_nxt     = '0;
      end
      DP_ALLOC_STEP: begin
        if (scan_lt && !got_full) begin
          mem_re        = 1'b1;
          mem_raddr     = scan_r[IDX_W-1:0];
          pend_vld_nxt  = 1'b1;
          pend_addr_nxt = scan_r[IDX_W-1:0];
          scan_nxt      = scan_r + 1'b1;
        end
        // link the previous free entry to this one, or record the chain head
        if (pend_vld_r && rd_zero && !got_full) begin
          if (have_prev_r) begin
            mem_we    = 1'b1;
            mem_waddr = prev_r;
            mem_wdata = FAT_W'(pend_addr_r);
          end else begin
            value_nxt = LIM_W'(pend_addr_r);
          end
          prev_nxt      = pend_addr_r;
          have_prev_nxt = 1'b1;
          got_nxt       = got_r + 1'b1;
        end
      end
      DP_ALLOC_END: begin
        mem_we    = 1'b1;
        mem_waddr = prev_r;
        mem_wdata = cfg_mark_r;
        stat_nxt  = STAT_OK;
      end
      DP_FREE_INIT: begin
        cur_nxt = req_idx;
        cnt_nxt = '0;
      end
      DP_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cur_r;
      end
      DP_FREE_EVAL: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        value_nxt = cnt_r + 1'b1;
        stat_nxt  = (rd_data_r >= END_THRESH) ? STAT_OK : STAT_CORRUPT;
        cur_nxt   = rd_data_r[IDX_W-1:0];
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_nxt.status       = stat_r;
      out_nxt.result_value = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limit_r <= LIMIT_RST;
      cfg_mark_r  <= MARK_RST;
      clr_r       <= '0;
      pend_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == CFG_ENTRY_LIMIT) begin
        cfg_limit_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_END_MARK) begin
        cfg_mark_r <= cfg_data[FAT_W-1:0];
      end
      clr_r      <= clr_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    scan_r      <= scan_nxt;
    pend_addr_r <= pend_addr_nxt;
    cnt_r       <= cnt_nxt;
    got_r       <= got_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    cur_r       <= cur_nxt;
    stat_r      <= stat_nxt;
    value_r     <= value_nxt;
    out_r       <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### design/fccm_ctrl.sv
`timescale 1ns / 1ps
// Controller: request sequencing state machine and result valid flag.
// Commands fccm_dp through dp_cmd_t; depends on fccm_pkg.
module fccm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fccm_pkg::dp_sts_t   sts,
  output fccm_pkg::dp_cmd_t   cmd
);
  import fccm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   out_free;

  assign out_free  = !out_vld_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_READ:  state_nxt = sts.bad_idx ? S_DONE : S_RD_WAIT;
          MODE_WRITE: state_nxt = S_DONE;
          MODE_ALLOC: state_nxt = sts.zero_cnt ? S_DONE : S_COUNT;
          MODE_FREE:  state_nxt = sts.free_bad_start ? S_DONE : S_FREE_RD;
          MODE_COUNT: state_nxt = S_COUNT;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_RD_WAIT: begin
        state_nxt = S_DONE;
      end
      S_COUNT: begin
        if (sts.scan_done) begin
          state_nxt = (sts.mode == MODE_ALLOC && !sts.no_space) ? S_ALLOC : S_DONE;
        end
      end
      S_ALLOC: begin
        if (sts.alloc_done) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE_RD: begin
        state_nxt = sts.walk_over ? S_DONE : S_FREE_EVAL;
      end
      S_FREE_EVAL: begin
        state_nxt = (sts.walk_end || sts.walk_bad) ? S_DONE : S_FREE_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.op         = DP_NOP;
    cmd.fin_status = STAT_OK;
    cmd.load_out   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LATCH;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_READ: begin
            cmd.op         = sts.bad_idx ? DP_FIN_ZERO : DP_RD_ISSUE;
            cmd.fin_status = STAT_BAD_INDEX;
          end
          MODE_WRITE: begin
            cmd.op         = sts.bad_idx ? DP_FIN_ZERO : DP_WRITE;
            cmd.fin_status = STAT_BAD_INDEX;
          end
          MODE_ALLOC: begin
            cmd.op         = sts.zero_cnt ? DP_FIN_ZERO : DP_SCAN_INIT;
            cmd.fin_status = STAT_BAD_COUNT;
          end
          MODE_FREE: begin
            cmd.op         = sts.free_bad_start ? DP_FIN_ZERO : DP_FREE_INIT;
            cmd.fin_status = STAT_BAD_INDEX;
          end
          MODE_COUNT: begin
            cmd.op = DP_SCAN_INIT;
          end
          default: begin
            cmd.op = DP_FIN_ZERO;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.op = DP_RD_DONE;
      end
      S_COUNT: begin
        if (!sts.scan_done) begin
          cmd.op = DP_CNT_STEP;
        end else if (sts.mode == MODE_ALLOC) begin
          cmd.op         = sts.no_space ? DP_FIN_ZERO : DP_ALLOC_INIT;
          cmd.fin_status = STAT_NO_SPACE;
        end else begin
          cmd.op = DP_FIN_COUNT;
        end
      end
      S_ALLOC: begin
        cmd.op = sts.alloc_done ? DP_ALLOC_END : DP_ALLOC_STEP;
      end
      S_FREE_RD: begin
        cmd.op         = sts.walk_over ? DP_FIN_COUNT : DP_FREE_RD;
        cmd.fin_status = STAT_CORRUPT;
      end
      S_FREE_EVAL: begin
        cmd.op = DP_FREE_EVAL;
      end
      S_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // hold the result until taken
  assign out_vld_nxt = cmd.load_out ? 1'b1 : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

### design/fat12_cluster_chain_manager_unit.sv
`timescale 1ns / 1ps
// Top level of the FAT12 cluster chain manager: controller plus datapath.
// Depends on fccm_pkg, fccm_ctrl and fccm_dp.
//
//   port group | direction | handshake          | payload
//   in_        | request   | in_valid/in_stall   | in_item_t
//   out_       | result    | out_valid/out_stall | out_item_t
//   cfg_       | register  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Count and allocate scan the table one entry per cycle through its single read port, up
// to the effective entry limit; allocate first counts the free entries and then scans again
// to link them. Free walks the chain, reading and then clearing each link. After reset a
// clearing pass rewrites all 4096 table entries; requests stall meanwhile. A finished
// result waits in the output register while the next request is accepted.
module fat12_cluster_chain_manager_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fccm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fccm_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fccm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fccm_pkg::LIM_W-1:0]      cfg_data
);
  import fccm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fccm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fccm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

### design/fccm_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the FAT12 cluster chain manager, bound to the top level.
// Depends on fccm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fccm_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input fccm_pkg::out_item_t             out_data
);
  import fccm_pkg::*;

  logic out_held;
  logic out_err;

  assign out_held = out_valid && out_stall;
  assign out_err  = out_data.status == STAT_NO_SPACE || out_data.status == STAT_BAD_INDEX ||
                    out_data.status == STAT_BAD_COUNT;

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_held |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_held |=> $stable(out_data), "stalled result changed")
  `ASSERT_NEVER(a_status_code, clk, rst_n, out_valid && out_data.status > STAT_BAD_COUNT, "bad code")
  `ASSERT_CLK(a_err_zero, clk, rst_n, out_valid && out_err |-> out_data.result_value == '0, "err value")
  `ASSERT_CLK(a_clear_stall, clk, rst_n, $past(!rst_n) |-> in_stall && !out_valid, "taken in clear")

endmodule

bind fat12_cluster_chain_manager_unit fccm_chk u_fccm_chk (.*);
